@@ sv/tsmc_pkg.sv @@
// Shared types and constants for the transport-synced MIDI clock block.
// Used by the divider, the datapath, the controller and the top level.
// No dependencies.
package tsmc_pkg;

  // Block geometry
  localparam int MAX_BLOCK         = 32;
  localparam int TICKS_PER_QUARTER = 24;
  localparam int RATE_W            = 18;
  localparam int DIVD_W            = 72;   // divider dividend / quotient width
  localparam int DIVS_W            = 56;   // divider divisor width
  localparam int DIV_STEPS         = 72;
  localparam int DIV_CNT_W         = 7;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
  localparam logic [55:0] PHASE_MAX  = 56'hFF_FFFF_FFFF_FFFF;
  localparam logic [55:0] ONE_SAMPLE = 56'h00_0001_0000_0000;
  localparam logic [56:0] OFFSET_EPS = 57'd429;

  // MIDI real-time and song position status bytes
  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
  localparam logic [7:0] MIDI_START    = 8'hFA;
  localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
  localparam logic [7:0] MIDI_STOP     = 8'hFC;
  localparam logic [7:0] MIDI_SPP      = 8'hF2;

  typedef enum logic [2:0] {
    EV_STOP,
    EV_START,
    EV_SPP,
    EV_CONT,
    EV_CLOCK
  } ev_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_STOP_IDLE,
    S_DIV_SPC,
    S_SPC,
    S_FRAC_GO,
    S_DIV_FRAC,
    S_DRIFT,
    S_STOP_DRIFT,
    S_START,
    S_MUL_LO,
    S_MUL_ADD,
    S_ANNOUNCE,
    S_CONT,
    S_TICK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     hold_tempo;
    logic     div_start;
    logic     div_frac;     // 0: clock period, 1: tick fraction
    logic     spc_load;
    logic     set_run;
    logic     clr_run;
    logic     start_init;
    logic     mul_hi;
    logic     mul_lo;
    logic     mul_add;
    logic     phase_wrap;
    logic     emit;
    ev_kind_t ev_kind;
    logic     ev_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic playing;
    logic running;
    logic zero_work;
    logic tempo_avail;
    logic known;
    logic div_busy;
    logic drift_stop;
    logic pos_pos;
    logic pending;
    logic last_tick;
    logic slot_free;
  } status_t;

endpackage

@@ sv/tsmc_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Serves the clock-period and tick-fraction divisions. Depends on tsmc_pkg.
module tsmc_div
  import tsmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVD_W-1:0]    dq_r, dq_nxt;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [DIVS_W:0]      shifted;
  logic [DIVS_W+1:0]    trial;
  logic                 ge;

  // One shift-subtract step
  always_comb begin
    shifted = {rem_r, dq_r[DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~trial[DIVS_W+1];
    rem_nxt = ge ? trial[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    dq_nxt  = {dq_r[DIVD_W-2:0], ge};
  end

  // Control: step counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) busy_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

@@ sv/tsmc_dp.sv @@
// Datapath: input latch, rate/tempo/phase state, divider, multiplier and
// output register. Depends on tsmc_pkg and tsmc_div.
module tsmc_dp
  import tsmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  input  logic [95:0]       in_tdata,
  output logic [31:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tvalid,
  input  logic              out_tready
);

  // Latched input transaction
  logic        playing_r, tvalid_r, known_r;
  logic [31:0] tempo_r;
  logic [47:0] pos_r;
  logic [5:0]  count_r;

  // Block state
  logic [RATE_W-1:0] rate_r;
  logic              running_r;
  logic [31:0]       held_r;
  logic [47:0]       nt_r;
  logic [55:0]       s_r;
  logic [55:0]       spc_r;
  logic [47:0]       prod_r;

  // Output register
  logic        ovalid_r, olast_r;
  logic [26:0] odata_r;

  // Divider hookup
  logic [DIVD_W-1:0] div_dividend, div_q;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_busy;

  logic [35:0]        limit;
  logic               tempo_ok;
  logic [31:0]        eff_tempo;
  logic [5:0]         cnt, cnt_m1;
  logic [47:0]        pos_eff;
  logic signed [52:0] pos53, ppq;
  logic [15:0]        diff16;
  logic [53:0]        ntsum;
  logic [47:0]        nt_new;
  logic signed [63:0] drift;
  logic [55:0]        spc_val;
  logic [31:0]        mul_b;
  logic [47:0]        prod;
  logic [56:0]        acc_sum, adv_sum, off_sum;
  logic [55:0]        s_adv, cnt_sh;
  logic [24:0]        off_raw;
  logic [5:0]         off;
  logic [7:0]         ev_status;
  logic [6:0]         ev_lo, ev_hi;
  logic [4:0]         ev_off;
  logic               ev_last;

  tsmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Tempo check and clock period numerator (rate * 60 * 65536 / 24)
  always_comb begin
    limit     = ({18'd0, rate_r} << 15) + ({18'd0, rate_r} << 17);
    tempo_ok  = tvalid_r && (tempo_r != 32'd0) && ({4'd0, tempo_r} <= limit);
    eff_tempo = tempo_ok ? tempo_r : held_r;
    cnt       = (count_r > 6'(MAX_BLOCK)) ? 6'(MAX_BLOCK) : count_r;
    cnt_m1    = cnt - 6'd1;
    cnt_sh    = {18'd0, cnt, 32'd0};
  end

  // Position in Q.16 ticks and start alignment
  always_comb begin
    pos_eff = known_r ? pos_r : 48'd0;
    pos53   = {{5{pos_eff[47]}}, pos_eff};
    ppq     = (pos53 <<< 4) + (pos53 <<< 3);
    diff16  = 16'd0 - ppq[15:0];
    ntsum   = {ppq[52], ppq} + 54'd65535;
    nt_new  = {{10{ntsum[53]}}, ntsum[53:16]};
    drift   = {{11{ppq[52]}}, ppq} + {24'd0, div_q[39:0]} - {nt_r, 16'd0};
  end

  // Divider operand select and period saturation
  always_comb begin
    if (cmd.div_frac) begin
      div_dividend = {s_r, 16'd0};
      div_divisor  = spc_r;
    end else begin
      div_dividend = {4'd0, limit, 32'd0};
      div_divisor  = {24'd0, eff_tempo};
    end
    if (|div_q[DIVD_W-1:56])           spc_val = PHASE_MAX;
    else if (div_q[55:0] < ONE_SAMPLE) spc_val = ONE_SAMPLE;
    else                               spc_val = div_q[55:0];
  end

  // Start phase multiplier, high then low half of the period
  always_comb begin
    mul_b   = cmd.mul_hi ? {8'd0, spc_r[55:32]} : spc_r[31:0];
    prod    = 48'(diff16 * mul_b);
    acc_sum = {1'b0, s_r} + {25'd0, prod_r[47:16]};
  end

  // Clock placement
  always_comb begin
    adv_sum = {1'b0, s_r} + {1'b0, spc_r};
    s_adv   = adv_sum[56] ? PHASE_MAX : adv_sum[55:0];
    off_sum = {1'b0, s_r} - OFFSET_EPS + 57'hFFFF_FFFF;
    off_raw = (s_r <= OFFSET_EPS[55:0]) ? 25'd0 : off_sum[56:32];
    off     = (off_raw > {19'd0, cnt_m1}) ? cnt_m1 : off_raw[5:0];
  end

  // Event formatting
  always_comb begin
    ev_lo   = 7'd0;
    ev_hi   = 7'd0;
    ev_off  = 5'd0;
    ev_last = cmd.ev_last;
    case (cmd.ev_kind)
      EV_STOP:  ev_status = MIDI_STOP;
      EV_START: ev_status = MIDI_START;
      EV_SPP: begin
        ev_status = MIDI_SPP;
        ev_lo     = pos_eff[20:14];
        ev_hi     = pos_eff[27:21];
      end
      EV_CONT:  ev_status = MIDI_CONTINUE;
      EV_CLOCK: begin
        ev_status = MIDI_CLOCK;
        ev_off    = off[4:0];
        ev_last   = st.last_tick;
      end
      default:  ev_status = MIDI_STOP;
    endcase
  end

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      playing_r <= in_tdata[0];
      tempo_r   <= in_tdata[32:1];
      tvalid_r  <= in_tdata[33];
      pos_r     <= in_tdata[81:34];
      known_r   <= in_tdata[82];
      count_r   <= in_tdata[88:83];
    end
  end

  // Rate register and transport state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RATE_RESET;
      running_r <= 1'b0;
      held_r    <= '0;
      nt_r      <= '0;
      s_r       <= '0;
    end else begin
      if (cfg_we) rate_r <= cfg_wdata;
      if (cmd.set_run)      running_r <= 1'b1;
      else if (cmd.clr_run) running_r <= 1'b0;
      if (cmd.hold_tempo && tempo_ok) held_r <= tempo_r;
      if (cmd.start_init) nt_r <= nt_new;
      else if (cmd.emit && cmd.ev_kind == EV_CLOCK) nt_r <= nt_r + 48'd1;
      if (cmd.mul_lo)       s_r <= {prod_r[39:0], 16'd0};
      else if (cmd.mul_add) s_r <= acc_sum[56] ? PHASE_MAX : acc_sum[55:0];
      else if (cmd.emit && cmd.ev_kind == EV_CLOCK) s_r <= s_adv;
      else if (cmd.phase_wrap) s_r <= s_r - cnt_sh;
    end
  end

  // Period and product registers
  always_ff @(posedge clk) begin
    if (cmd.spc_load) spc_r <= spc_val;
    if (cmd.mul_hi || cmd.mul_lo) prod_r <= prod;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      odata_r <= {ev_off, ev_hi, ev_lo, ev_status};
      olast_r <= ev_last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, odata_r};
  assign out_tlast  = olast_r;

  // Status to controller
  always_comb begin
    st.playing     = playing_r;
    st.running     = running_r;
    st.zero_work   = (count_r == 6'd0) || (rate_r == '0);
    st.tempo_avail = (eff_tempo != 32'd0);
    st.known       = known_r;
    st.div_busy    = div_busy;
    st.drift_stop  = (drift >= (64'sd1 * TICKS_PER_QUARTER) <<< 16) ||
                     (drift <= -((64'sd1 * TICKS_PER_QUARTER) <<< 16));
    st.pos_pos     = $signed(pos_eff) > 48'sd0;
    st.pending     = s_r < cnt_sh;
    st.last_tick   = s_adv >= cnt_sh;
    st.slot_free   = ~ovalid_r | out_tready;
  end

endmodule

@@ sv/tsmc_ctrl.sv @@
// Controller state machine: sequences divisions, alignment and event output.
// Depends on tsmc_pkg.
module tsmc_ctrl
  import tsmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!st.playing) begin
          state_nxt = st.running ? S_STOP_IDLE : S_IDLE;
        end else if (st.zero_work) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.hold_tempo = 1'b1;
          if (st.tempo_avail) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV_SPC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_STOP_IDLE: begin
        if (st.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = EV_STOP;
          cmd.ev_last = 1'b1;
          cmd.clr_run = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DIV_SPC: begin
        if (!st.div_busy) state_nxt = S_SPC;
      end
      S_SPC: begin
        cmd.spc_load = 1'b1;
        if (st.running && st.known) state_nxt = S_FRAC_GO;
        else if (st.running)        state_nxt = S_TICK;
        else                        state_nxt = S_START;
      end
      S_FRAC_GO: begin
        cmd.div_frac  = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_FRAC;
      end
      S_DIV_FRAC: begin
        if (!st.div_busy) state_nxt = S_DRIFT;
      end
      S_DRIFT: begin
        state_nxt = st.drift_stop ? S_STOP_DRIFT : S_TICK;
      end
      S_STOP_DRIFT: begin
        if (st.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = EV_STOP;
          cmd.clr_run = 1'b1;
          state_nxt   = S_START;
        end
      end
      // Re-align: tick index, run flag, first product of the start phase
      S_START: begin
        cmd.start_init = 1'b1;
        cmd.set_run    = 1'b1;
        cmd.mul_hi     = 1'b1;
        state_nxt      = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_ADD;
      end
      S_MUL_ADD: begin
        cmd.mul_add = 1'b1;
        state_nxt   = S_ANNOUNCE;
      end
      S_ANNOUNCE: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          if (st.pos_pos) begin
            cmd.ev_kind = EV_SPP;
            state_nxt   = S_CONT;
          end else begin
            cmd.ev_kind = EV_START;
            cmd.ev_last = ~st.pending;
            state_nxt   = S_TICK;
          end
        end
      end
      S_CONT: begin
        if (st.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.ev_kind = EV_CONT;
          cmd.ev_last = ~st.pending;
          state_nxt   = S_TICK;
        end
      end
      // One clock per cycle while the phase lies inside the block and the output slot is free
      S_TICK: begin
        if (st.pending) begin
          if (st.slot_free) begin
            cmd.emit    = 1'b1;
            cmd.ev_kind = EV_CLOCK;
            cmd.ev_last = st.last_tick;
          end
        end else begin
          cmd.phase_wrap = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ sv/transport_synced_midi_clock_top.sv @@
// Top level of the transport-synced MIDI clock generator (24 per quarter).
// Joins the controller and the datapath. Depends on tsmc_pkg, tsmc_ctrl and tsmc_dp.
//
// Usage: one transaction on the in_ channel carries the transport report of
// one audio block. The block answers with zero to 35 MIDI events
// on the out_ channel; out_tlast marks the final event of a report.
// The sample rate is set through cfg_we/cfg_wdata; the user must write it only
// while no report is in flight (the block does not enforce this). It resets to 48000.
// Timing: a playing report runs the clock-period division, 72 steps in a
// shared radix-2 divider, after accept and decode and before the period load.
// A drift check adds the tick-fraction division on the same divider; a start or
// restart adds the alignment states S_START, S_MUL_LO and S_MUL_ADD; the events
// follow, then the closing phase update. Stopped, empty or tempo-less reports
// return to idle after decode, through a Stop event where one is due.
// in_tready is high only between reports.
// Reset: synchronous active-low rst_n stops the transport, clears the held
// tempo, tick index and phase, and empties the output register.
// Backpressure: events sit in a single output register; when out_tready is
// low the sequencer holds until the register frees up, losing nothing.
module transport_synced_midi_clock_top
  import tsmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration: sample_rate_hz
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  // in_tdata: playing[0], tempo[32:1], tempo_valid[33], position[81:34],
  //           position_known[82], sample_count[88:83], zero fill above
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,
  // out_tdata: status_byte[7:0], data_low[14:8], data_high[21:15],
  //            sample_offset[26:22], zero fill above
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);

  cmd_t    cmd;
  status_t st;

  tsmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tsmc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the transport-synced MIDI clock generator.
// Drives transport reports, predicts the MIDI event stream, checks the out_ channel.
// Depends on tsmc_pkg and transport_synced_midi_clock_top.
`timescale 1ns / 100ps

module tb
  import tsmc_pkg::*;
();

  localparam longint unsigned MASK48     = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned PHASE_SAT  = 64'h00FF_FFFF_FFFF_FFFF;
  localparam longint unsigned ONE_SMP    = 64'h1_0000_0000;
  localparam longint unsigned PERIOD_K   = 64'd163840;  // 60 * 65536 / 24
  localparam longint unsigned EPS        = 64'd429;
  localparam longint unsigned LOW32      = 64'hFFFF_FFFF;

  typedef struct {
    bit              playing;
    bit [31:0]       tempo;
    bit              tempo_valid;
    bit [47:0]       position;
    bit              known;
    bit [5:0]        count;
    bit [7:0]        first_status;  // 0: not typed in
  } report_t;

  typedef struct {
    bit [7:0] status;
    bit [6:0] lo;
    bit [6:0] hi;
    bit [4:0] offset;
    bit       last;
  } midi_evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [17:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  transport_synced_midi_clock_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #1 clk = ~clk;

  // Shadow of the block state
  longint unsigned sh_rate, sh_tempo, sh_tick_idx, sh_phase;
  bit              sh_running;
  midi_evt_t       pending_evts[$];
  int              err_cnt = 0;

  // Clock period in Q24.32 samples
  function automatic longint unsigned clock_period(longint unsigned rate, longint unsigned t);
    longint unsigned num, q, r, p;
    num = rate * PERIOD_K;
    q = num / t;
    r = num % t;
    if (q >= (64'd1 << 24)) return PHASE_SAT;
    p = (q << 32) | ((r << 32) / t);
    if (p < ONE_SMP) p = ONE_SMP;
    return p;
  endfunction

  // Phase over period, in Q.16 ticks
  function automatic longint unsigned tick_frac(longint unsigned s, longint unsigned spc);
    longint unsigned rem, f;
    rem = s % spc;
    f = s / spc;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      f = f << 1;
      if (rem >= spc) begin
        rem = rem - spc;
        f = f | 64'd1;
      end
    end
    return f;
  endfunction

  function automatic midi_evt_t mk_evt(bit [7:0] st, bit [6:0] lo, bit [6:0] hi, bit [4:0] off);
    midi_evt_t e;
    e.status = st; e.lo = lo; e.hi = hi; e.offset = off; e.last = 1'b0;
    return e;
  endfunction

  // Expected MIDI events for one report; returns the first status (0 if none)
  function automatic bit [7:0] predict_events(report_t r);
    midi_evt_t       evs[$];
    longint unsigned cnt, limit, spc, d, mag, diff, s, off, tmp, spp;
    longint          pos, ppq, nt;
    if (!r.playing) begin
      if (sh_running) begin
        sh_running = 1'b0;
        evs.push_back(mk_evt(MIDI_STOP, 0, 0, 0));
      end
    end else if (r.count != 0 && sh_rate != 0) begin
      cnt = (r.count > MAX_BLOCK) ? MAX_BLOCK : r.count;
      limit = sh_rate * PERIOD_K;
      if (r.tempo_valid && r.tempo != 0 && r.tempo <= limit) sh_tempo = r.tempo;
      if (sh_tempo != 0) begin
        spc = clock_period(sh_rate, sh_tempo);
        pos = r.known ? longint'({{16{r.position[47]}}, r.position}) : 0;
        ppq = pos * 24;
        // Drift check against the running clock
        if (sh_running && r.known) begin
          nt = longint'({{16{sh_tick_idx[47]}}, sh_tick_idx[47:0]});
          d = longint'(ppq) + tick_frac(sh_phase, spc) - longint'(nt << 16);
          mag = d[63] ? (64'd0 - d) : d;
          if (mag >= (64'd24 << 16)) begin
            sh_running = 1'b0;
            evs.push_back(mk_evt(MIDI_STOP, 0, 0, 0));
          end
        end
        // Start or resume, aligned to the next tick
        if (!sh_running) begin
          tmp = (longint'(ppq + (longint'(1) << 53)) + 64'd65535) >> 16;
          nt = longint'(tmp) - (longint'(1) << 37);
          diff = nt * 65536 - ppq;
          sh_tick_idx = nt & MASK48;
          sh_running = 1'b1;
          if (pos <= 0) evs.push_back(mk_evt(MIDI_START, 0, 0, 0));
          else begin
            spp = (longint'(pos) >> 14) & 64'd16383;
            evs.push_back(mk_evt(MIDI_SPP, spp[6:0], spp[13:7], 0));
            evs.push_back(mk_evt(MIDI_CONTINUE, 0, 0, 0));
          end
          sh_phase = ((diff * (spc >> 32)) << 16) + ((diff * (spc & LOW32)) >> 16);
          if (sh_phase > PHASE_SAT) sh_phase = PHASE_SAT;
        end
        // Timing clocks inside the block
        while (sh_phase < (cnt << 32)) begin
          s = sh_phase;
          off = (s <= EPS) ? 0 : ((s - EPS + LOW32) >> 32);
          if (off > cnt - 1) off = cnt - 1;
          evs.push_back(mk_evt(MIDI_CLOCK, 0, 0, off[4:0]));
          sh_phase = (s > PHASE_SAT - spc) ? PHASE_SAT : s + spc;
          sh_tick_idx = (sh_tick_idx + 1) & MASK48;
        end
        sh_phase = sh_phase - (cnt << 32);
      end
    end
    if (evs.size() == 0) return 8'h00;
    evs[$].last = 1'b1;
    foreach (evs[i]) pending_evts.push_back(evs[i]);
    return evs[0].status;
  endfunction

  // Sender: one transaction per report, random gap before each
  bit burst_in = 1'b0;
  task automatic send_report(report_t r);
    bit [7:0] first;
    int gap;
    if ($urandom_range(0, 15) == 0) burst_in = ~burst_in;
    gap = burst_in ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {7'd0, r.count, r.known, r.position, r.tempo_valid, r.tempo, r.playing};
    do @(posedge clk); while (!in_tready);
    first = predict_events(r);
    if (r.first_status != 0 && first != r.first_status) begin
      $error("status_byte: expected %h, actual %h", r.first_status, first);
      err_cnt++;
    end
    @(negedge clk);
  endtask

  task automatic write_rate(bit [17:0] v);
    in_tvalid = 1'b0;
    wait (pending_evts.size() == 0);
    repeat (200) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sh_rate = v;
  endtask

  function automatic report_t rpt(bit pl, bit [31:0] tp, bit tv, bit [47:0] ps, bit kn,
                                  bit [5:0] c, bit [7:0] fs);
    report_t r;
    r.playing = pl; r.tempo = tp; r.tempo_valid = tv; r.position = ps;
    r.known = kn; r.count = c; r.first_status = fs;
    return r;
  endfunction

  // Receiver: random stall before each event, with stall-free stretches
  initial begin
    bit burst_out;
    int k;
    burst_out = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) burst_out = ~burst_out;
      k = burst_out ? 0 : $urandom_range(0, 8);
      if (k > 0) begin
        out_tready = 1'b0;
        repeat (k) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Output checker
  always @(posedge clk) begin
    midi_evt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_evts.size() == 0) begin
        $error("unexpected event: tdata %h", out_tdata);
        err_cnt++;
      end else begin
        e = pending_evts.pop_front();
        if (out_tdata[7:0] != e.status) begin
          $error("status_byte: expected %h, actual %h", e.status, out_tdata[7:0]);
          err_cnt++;
        end
        if (out_tdata[14:8] != e.lo) begin
          $error("data_low: expected %0d, actual %0d", e.lo, out_tdata[14:8]);
          err_cnt++;
        end
        if (out_tdata[21:15] != e.hi) begin
          $error("data_high: expected %0d, actual %0d", e.hi, out_tdata[21:15]);
          err_cnt++;
        end
        if (out_tdata[26:22] != e.offset) begin
          $error("sample_offset: expected %0d, actual %0d", e.offset, out_tdata[26:22]);
          err_cnt++;
        end
        if (out_tlast != e.last) begin
          $error("last_event: expected %0d, actual %0d", e.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  localparam bit [31:0] BPM120 = 32'd120 << 16;

  // Stimulus
  initial begin
    report_t         dir_tbl[$];
    report_t         r;
    bit [17:0]       rate_list[6];
    longint          song_pos;
    bit [31:0]       cur_tempo;
    int              sel;
    longint unsigned adv;
    rate_list = '{18'd44100, 18'd192000, 18'd1, 18'd0, 18'd96000, 18'd48000};
    sh_rate = 48000; sh_running = 0; sh_tempo = 0; sh_tick_idx = 0; sh_phase = 0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: rejected tempo, empty and long blocks, start/SPP/drift, extremes
    dir_tbl.push_back(rpt(0, BPM120, 1, 0, 1, 16, 8'h00));
    dir_tbl.push_back(rpt(1, 0, 1, 0, 1, 16, 8'h00));
    dir_tbl.push_back(rpt(1, BPM120, 0, 0, 1, 16, 8'h00));
    dir_tbl.push_back(rpt(1, BPM120, 1, 0, 1, 32, MIDI_START));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'd1, 1, 32, 8'h00));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'd1, 1, 0, 8'h00));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'd2, 1, 63, 8'h00));
    dir_tbl.push_back(rpt(0, BPM120, 1, 48'd2, 1, 32, MIDI_STOP));
    dir_tbl.push_back(rpt(0, BPM120, 1, 48'd2, 1, 32, 8'h00));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'd8 << 16, 1, 20, MIDI_SPP));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'd100 << 16, 1, 20, MIDI_STOP));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'hFFFF_FFFF_FFFF, 0, 20, 8'h00));
    dir_tbl.push_back(rpt(1, 32'hFFFF_FFFF, 1, 48'd100 << 16, 0, 32, 8'h00));
    dir_tbl.push_back(rpt(0, 0, 0, 0, 0, 1, MIDI_STOP));
    dir_tbl.push_back(rpt(1, 32'hFFFF_FFFF, 1, 48'h7FFF_FFFF_FFFF, 1, 32, MIDI_SPP));
    dir_tbl.push_back(rpt(0, 0, 0, 0, 0, 0, MIDI_STOP));
    dir_tbl.push_back(rpt(1, 32'd1, 1, 48'h8000_0000_0000, 1, 1, MIDI_START));
    dir_tbl.push_back(rpt(1, 32'd1, 1, 48'h8000_0000_0000, 1, 32, 8'h00));
    dir_tbl.push_back(rpt(0, 0, 0, 0, 0, 5, MIDI_STOP));
    dir_tbl.push_back(rpt(1, BPM120, 1, 48'hFFFF_FFFF_0000, 1, 1, MIDI_START));
    foreach (dir_tbl[i]) send_report(dir_tbl[i]);

    // Random phases, one per sample rate
    foreach (rate_list[p]) begin
      write_rate(rate_list[p]);
      song_pos = 0;
      cur_tempo = $urandom_range(60, 200) << 16;
      for (int i = 0; i < 36; i++) begin
        sel = $urandom_range(0, 99);
        r = rpt(1, cur_tempo, 1, song_pos[47:0], 1, 6'($urandom_range(1, 32)), 8'h00);
        if (sel < 7) r.playing = 1'b0;
        else if (sel < 12) begin
          song_pos = longint'($urandom_range(0, 400)) << 14;
          r.position = song_pos[47:0];
        end else if (sel < 16) begin
          cur_tempo = $urandom_range(30, 300) << 16 | $urandom_range(0, 65535);
          r.tempo = cur_tempo;
        end else if (sel < 24) begin
          r.playing = 1'($urandom_range(0, 1));
          r.tempo = $urandom();
          r.tempo_valid = 1'($urandom_range(0, 1));
          r.position = 48'({$urandom(), $urandom()});
          r.known = 1'($urandom_range(0, 1));
          r.count = 6'($urandom_range(0, 63));
        end
        send_report(r);
        if (r.playing && sh_rate != 0) begin
          adv = (longint'(r.count > 32 ? 32 : r.count) * cur_tempo) / (60 * sh_rate);
          song_pos = song_pos + longint'(adv);
        end
      end
    end

    in_tvalid = 1'b0;
    wait (pending_evts.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && pending_evts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
